// ===== src/float_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the checker file of the decimal text converter.
`ifndef FLOAT_TO_DECIMAL_ASCII_MACROS_SVH
`define FLOAT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define FTOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ftoa assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define FTOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ftoa assertion failed");

`endif

// ===== src/ftoa_pkg.sv =====
// Types and constants shared by the modules of the decimal text converter.
package ftoa_pkg;

  localparam int IntDigits  = 10;
  localparam int BcdBits    = IntDigits * 4;
  localparam int IntBits    = 31;
  localparam int FracBits   = 56;
  localparam int StepBits   = 4;
  localparam int QueueDepth = 2;

  localparam logic [7:0]         CharZero  = 8'h30;
  localparam logic [7:0]         CharNine  = 8'h39;
  localparam logic [7:0]         CharMinus = 8'h2D;
  localparam logic [7:0]         CharPoint = 8'h2E;
  localparam logic [3:0]         MaxFrac   = 4'd9;
  localparam logic [3:0]         FracDigitsReset = 4'd2;
  localparam logic [IntBits-1:0] SatInt    = 31'h7FFF_FFFF;
  localparam logic [7:0]         ExpoSpecial = 8'hFF;

  typedef logic [IntDigits-1:0][3:0] bcd_t;

  // One converted number waiting to be printed.
  typedef struct packed {
    logic                neg;
    logic                sat;
    logic [3:0]          ndig;
    bcd_t                bcd;
    logic [FracBits-1:0] frac;
  } entry_t;

endpackage

// ===== src/ftoa_if.sv =====
// Valid/ready channel interfaces for the input and output items.
interface ftoa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface ftoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       saturated;

  modport source (output valid, output text_char, output last_char, output saturated,
                  input ready);
  modport sink (input valid, input text_char, input last_char, input saturated,
                output ready);
endinterface

// ===== src/ftoa_fifo.sv =====
// Small register queue of converted numbers between front and back.
module ftoa_fifo #(
  parameter int Depth = ftoa_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ftoa_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ftoa_pkg::entry_t data_o,
  output logic            empty_o
);

  // Depth of two or more keeps the pointers at least one bit wide.
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ftoa_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/ftoa_front.sv =====
// Front end: accepts a float, splits it into integer and fraction, converts the integer to BCD.
module ftoa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ftoa_in_if.sink          in_i,
  output logic             push_o,
  output ftoa_pkg::entry_t data_o,
  input  logic             full_i
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} state_e;

  state_e                        state_q, state_d;
  logic                          neg_q, neg_d;
  logic                          sat_q, sat_d;
  logic [ftoa_pkg::FracBits-1:0] frac_q, frac_d;
  logic [31:0]                   bin_q, bin_d;
  ftoa_pkg::bcd_t                bcd_q, bcd_d;
  logic [ftoa_pkg::StepBits-1:0] step_q, step_d;

  logic [7:0]                    expo;
  logic [22:0]                   mant;
  logic [23:0]                   m24;
  logic [5:0]                    rsh;
  logic [79:0]                   wide;
  logic                          neg_c, sat_c;
  logic [ftoa_pkg::IntBits-1:0]  ipart_c;
  logic [ftoa_pkg::FracBits-1:0] frac_c;
  logic [3:0]                    ndig;

  // One double-dabble step: add three to every digit of five or more, then shift in a bit.
  function automatic ftoa_pkg::bcd_t dabble(input ftoa_pkg::bcd_t b, input logic b_in);
    ftoa_pkg::bcd_t               t;
    logic [ftoa_pkg::BcdBits-1:0] flat;
    t = b;
    for (int i = 0; i < ftoa_pkg::IntDigits; i++) begin
      if (t[i] >= 4'd5) begin
        t[i] = t[i] + 4'd3;
      end
    end
    flat = t;
    return {flat[ftoa_pkg::BcdBits-2:0], b_in};
  endfunction

  assign expo = in_i.value_bits[30:23];
  assign mant = in_i.value_bits[22:0];
  assign m24  = {expo != 8'd0, mant};
  assign rsh  = 6'(8'd150 - expo);
  // Mantissa placed above a 56-bit binary point, then shifted right by the exponent distance.
  assign wide = {m24, {ftoa_pkg::FracBits{1'b0}}} >> rsh;

  always_comb begin
    neg_c   = in_i.value_bits[31] && (in_i.value_bits[30:0] != 31'd0);
    sat_c   = 1'b0;
    ipart_c = '0;
    frac_c  = '0;
    if (expo == ftoa_pkg::ExpoSpecial) begin
      // NaN loses its sign; infinity keeps it.
      neg_c   = in_i.value_bits[31] && (mant == 23'd0);
      sat_c   = 1'b1;
      ipart_c = ftoa_pkg::SatInt;
    end else if (expo > 8'd157) begin
      sat_c   = 1'b1;
      ipart_c = ftoa_pkg::SatInt;
    end else if (expo >= 8'd150) begin
      ipart_c = {7'd0, m24} << (expo[2:0] - 3'd6);
    end else if (expo >= 8'd94) begin
      ipart_c = {7'd0, wide[79:56]};
      frac_c  = wide[ftoa_pkg::FracBits-1:0];
    end
    // Smaller magnitudes and denormals print zero in every position.
  end

  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < ftoa_pkg::IntDigits; i++) begin
      if (bcd_q[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  assign in_i.ready = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH);
  assign data_o     = '{neg: neg_q, sat: sat_q, ndig: ndig, bcd: bcd_q, frac: frac_q};

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    frac_d  = frac_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    step_d  = step_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          neg_d   = neg_c;
          sat_d   = sat_c;
          frac_d  = frac_c;
          bin_d   = {1'b0, ipart_c};
          bcd_d   = '0;
          step_d  = '0;
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        bcd_d  = dabble(dabble(bcd_q, bin_q[31]), bin_q[30]);
        bin_d  = {bin_q[29:0], 2'b00};
        step_d = step_q + ftoa_pkg::StepBits'(1);
        if (step_q == '1) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      frac_q  <= '0;
      bin_q   <= '0;
      bcd_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
      frac_q  <= frac_d;
      bin_q   <= bin_d;
      bcd_q   <= bcd_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== src/ftoa_back.sv =====
// Back end: takes converted numbers from the queue and prints them one character at a time.
module ftoa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [3:0]       frac_digits_i,
  input  logic             empty_i,
  input  ftoa_pkg::entry_t data_i,
  output logic             pop_o,
  ftoa_out_if.source       out_o
);

  typedef enum logic [2:0] {B_LOAD, B_SIGN, B_INT, B_POINT, B_FRAC} state_e;

  state_e                        state_q, state_d;
  logic                          sat_q, sat_d;
  ftoa_pkg::bcd_t                bcd_q, bcd_d;
  logic [3:0]                    idx_q, idx_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [ftoa_pkg::FracBits-1:0] frac_q, frac_d;
  logic                          ovalid_q, ovalid_d;
  logic [7:0]                    char_q, char_d;
  logic                          last_q, last_d;
  logic                          osat_q, osat_d;

  logic                          adv, emit, lst;
  logic [7:0]                    ch;
  logic [ftoa_pkg::FracBits+3:0] times_ten;

  assign adv       = !ovalid_q || out_o.ready;
  assign times_ten = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);

  assign out_o.valid     = ovalid_q;
  assign out_o.text_char = char_q;
  assign out_o.last_char = last_q;
  assign out_o.saturated = osat_q;

  always_comb begin
    state_d = state_q;
    sat_d   = sat_q;
    bcd_d   = bcd_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    frac_d  = frac_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    lst     = 1'b0;
    ch      = ftoa_pkg::CharZero;
    unique case (state_q)
      B_LOAD: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          sat_d   = data_i.sat;
          bcd_d   = data_i.bcd;
          idx_d   = data_i.ndig - 4'd1;
          frac_d  = data_i.frac;
          state_d = data_i.neg ? B_SIGN : B_INT;
        end
      end
      B_SIGN: begin
        if (adv) begin
          emit    = 1'b1;
          ch      = ftoa_pkg::CharMinus;
          state_d = B_INT;
        end
      end
      B_INT: begin
        if (adv) begin
          emit = 1'b1;
          ch   = ftoa_pkg::CharZero + {4'd0, bcd_q[idx_q]};
          lst  = (idx_q == 4'd0) && (frac_digits_i == 4'd0);
          if (idx_q == 4'd0) begin
            state_d = (frac_digits_i == 4'd0) ? B_LOAD : B_POINT;
          end else begin
            idx_d = idx_q - 4'd1;
          end
        end
      end
      B_POINT: begin
        if (adv) begin
          emit    = 1'b1;
          ch      = ftoa_pkg::CharPoint;
          cnt_d   = frac_digits_i;
          state_d = B_FRAC;
        end
      end
      B_FRAC: begin
        if (adv) begin
          emit   = 1'b1;
          ch     = ftoa_pkg::CharZero + {4'd0, times_ten[ftoa_pkg::FracBits+3:ftoa_pkg::FracBits]};
          frac_d = times_ten[ftoa_pkg::FracBits-1:0];
          lst    = (cnt_q == 4'd1);
          cnt_d  = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            state_d = B_LOAD;
          end
        end
      end
      default: state_d = B_LOAD;
    endcase

    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    osat_d   = osat_q;
    if (adv) begin
      ovalid_d = emit;
      char_d   = ch;
      last_d   = lst;
      osat_d   = sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_LOAD;
      sat_q    <= 1'b0;
      bcd_q    <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      frac_q   <= '0;
      ovalid_q <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
      osat_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sat_q    <= sat_d;
      bcd_q    <= bcd_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      frac_q   <= frac_d;
      ovalid_q <= ovalid_d;
      char_q   <= char_d;
      last_q   <= last_d;
      osat_q   <= osat_d;
    end
  end

endmodule

// ===== src/float_to_decimal_ascii.sv =====
// Top level of the single-precision float to decimal text converter.
//
//   Channel   Direction  Payload                              Item accepted when
//   in_i      in         value_bits[31:0]                     valid && ready
//   out_o     out        text_char[7:0], last_char, saturated valid && ready
//   cfg       in         cfg_wdata_i[3:0] (fraction digits)   cfg_we_i
//
// The front end takes an item while idle, turns its integer part into BCD (two double-dabble
// steps a cycle), then hands the number to the queue, waiting while the queue is full. The
// back end takes a number from the queue and then prints one character a cycle while the
// output is not stalled; the slower side sets the rate. The queue holds QueueDepth numbers,
// so the front end keeps converting while the output stalls, until the queue is full.
// Reset clears both ends and the queue and sets the fraction digit count to two.
module float_to_decimal_ascii #(
  parameter int QueueDepth = ftoa_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftoa_in_if.sink     in_i,
  ftoa_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  // Fraction digit count as written; values above nine print nine digits.
  logic [3:0]       frac_digits_q;
  logic [3:0]       frac_digits;

  ftoa_pkg::entry_t push_data, pop_data;
  logic             push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= ftoa_pkg::FracDigitsReset;
    end else if (cfg_we_i) begin
      frac_digits_q <= cfg_wdata_i;
    end
  end

  assign frac_digits = (frac_digits_q > ftoa_pkg::MaxFrac) ? ftoa_pkg::MaxFrac : frac_digits_q;

  // The front end classifies the float: sign, saturation, integer part in BCD and the
  // exact fraction as a 56-bit binary fixed-point value. Anything below 2^-56 cannot
  // reach the ninth decimal place, so it is dropped there.
  ftoa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .data_o (push_data),
    .full_i (full)
  );

  ftoa_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  // The back end prints sign, integer digits without leading zeros, the point and the
  // fraction digits; each fraction digit is the integer part of ten times the remaining
  // fraction, which gives truncated digits exactly. Its output register lets it take the
  // next number from the queue while the last character waits to be taken.
  ftoa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frac_digits_i (frac_digits),
    .empty_i       (empty),
    .data_i        (pop_data),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule

// ===== src/ftoa_checker.sv =====
// Port-level checks for the decimal text converter, bound to its top level.
`include "float_to_decimal_ascii_macros.svh"

module ftoa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  text_char_i,
  input logic        last_char_i,
  input logic        saturated_i
);

  logic       is_digit;
  logic       is_mark;
  logic [9:0] payload;

  assign is_digit = (text_char_i >= ftoa_pkg::CharZero) && (text_char_i <= ftoa_pkg::CharNine);
  assign is_mark  = (text_char_i == ftoa_pkg::CharMinus) || (text_char_i == ftoa_pkg::CharPoint);
  assign payload  = {text_char_i, last_char_i, saturated_i};

  `FTOA_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `FTOA_ASSERT_NEXT(a_out_payload_held, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(payload))
  `FTOA_ASSERT_NOW(a_char_set, clk_i, rst_ni, out_valid_i, is_digit || is_mark)
  `FTOA_ASSERT_NOW(a_last_is_digit, clk_i, rst_ni, out_valid_i && last_char_i, is_digit)

endmodule

bind float_to_decimal_ascii ftoa_checker u_ftoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .text_char_i (out_o.text_char),
  .last_char_i (out_o.last_char),
  .saturated_i (out_o.saturated)
);
